/* design/arpc_pkg.sv */
// Package for the ARP cache and responder.
// Holds the item and result structs, code constants, FSM states and table controls.
// No dependencies.
package arpc_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    // Configuration register map: 64-bit registers at 8-byte steps.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;
    localparam logic [1:0] REG_DYNAMIC_ARP = 2'd0;
    localparam logic [1:0] REG_LOCAL_MAC   = 2'd1;
    localparam logic [1:0] REG_LOCAL_IP    = 2'd2;

    // Item kinds.
    localparam logic [1:0] KIND_PKT     = 2'd0;
    localparam logic [1:0] KIND_ADD     = 2'd1;
    localparam logic [1:0] KIND_DEL     = 2'd2;
    localparam logic [1:0] KIND_RESOLVE = 2'd3;

    // Received ARP opcodes.
    localparam logic [15:0] OP_REQUEST = 16'h0001;
    localparam logic [15:0] OP_REPLY   = 16'h0002;

    // Emitted ARP opcodes.
    localparam logic [1:0] OUT_OP_NONE    = 2'd0;
    localparam logic [1:0] OUT_OP_REQUEST = 2'd1;
    localparam logic [1:0] OUT_OP_REPLY   = 2'd2;

    // Result status codes.
    localparam logic [2:0] STAT_DONE        = 3'd0;
    localparam logic [2:0] STAT_REPLY       = 3'd1;
    localparam logic [2:0] STAT_REQUEST     = 3'd2;
    localparam logic [2:0] STAT_HIT         = 3'd3;
    localparam logic [2:0] STAT_MISS        = 3'd4;
    localparam logic [2:0] STAT_DEL_MISSING = 3'd5;
    localparam logic [2:0] STAT_NO_RECORD   = 3'd6;
    localparam logic [2:0] STAT_FULL        = 3'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  port;
        logic [15:0] arp_operation;
        logic [47:0] peer_mac;
        logic [31:0] peer_ip;
        logic [31:0] target_ip;
        logic        cache_only;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_port;
        logic [1:0]  out_operation;
        logic [47:0] out_sender_mac;
        logic [31:0] out_sender_ip;
        logic [47:0] out_target_mac;
        logic [31:0] out_target_ip;
        logic [47:0] resolved_mac;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Table write controls for one cycle.
    typedef struct packed {
        logic key_we;     // write IP and port
        logic mac_we;     // write MAC
        logic set_valid;
        logic clr_valid;
    } t_tbl_ctl;

endpackage

/* design/arpc_table.sv */
// Binding table of the ARP cache: valid flags in flip-flops, IP/MAC/port in memory.
// One registered read port and one write port. Depends on arpc_pkg.
module arpc_table #(
    parameter int ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF,
    parameter int AW      = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  arpc_pkg::t_tbl_ctl i_ctl,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [31:0]        i_wr_ip,
    input  logic [47:0]        i_wr_mac,
    input  logic [7:0]         i_wr_port,
    input  logic               i_rd_en,
    input  logic [AW-1:0]      i_rd_addr,
    output logic               o_rd_valid,
    output logic [31:0]        o_rd_ip,
    output logic [47:0]        o_rd_mac,
    output logic [7:0]         o_rd_port
);
    import arpc_pkg::*;

    logic [ENTRIES-1:0] r_valid;
    logic [31:0]        r_mem_ip   [ENTRIES];
    logic [47:0]        r_mem_mac  [ENTRIES];
    logic [7:0]         r_mem_port [ENTRIES];
    logic               r_rd_valid;
    logic [31:0]        r_rd_ip;
    logic [47:0]        r_rd_mac;
    logic [7:0]         r_rd_port;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.set_valid) begin
            r_valid[i_wr_addr] <= 1'b1;
        end else if (i_ctl.clr_valid) begin
            r_valid[i_wr_addr] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.key_we) begin
            r_mem_ip[i_wr_addr]   <= i_wr_ip;
            r_mem_port[i_wr_addr] <= i_wr_port;
        end
        if (i_ctl.mac_we) begin
            r_mem_mac[i_wr_addr] <= i_wr_mac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_valid <= r_valid[i_rd_addr];
            r_rd_ip    <= r_mem_ip[i_rd_addr];
            r_rd_mac   <= r_mem_mac[i_rd_addr];
            r_rd_port  <= r_mem_port[i_rd_addr];
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_ip    = r_rd_ip;
    assign o_rd_mac   = r_rd_mac;
    assign o_rd_port  = r_rd_port;

endmodule

/* design/arp_cache_and_responder_unit.sv */
// ARP cache and responder, top level: APB register file, scan sequencer, result register.
// Table items (learn, add, delete, resolve) reach a registered result after a
// one-entry-per-cycle scan through the table's single read port; a new item is taken
// only after the result of the last one is registered. Received packets that do not
// learn skip the scan. A stalled output holds the result step and the next item.
// Synchronous active-low reset empties the table and clears the configuration registers to zero.
module arp_cache_and_responder_unit #(
    parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  arpc_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output arpc_pkg::t_out                      o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [arpc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [arpc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [arpc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import arpc_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    // Configuration registers.
    logic        r_dynamic_arp;
    logic [47:0] r_local_mac;
    logic [31:0] r_local_ip;

    t_state      r_state, n_state;
    t_in         r_item;
    logic [CW-1:0] r_cnt;
    logic        r_chk;
    logic [AW-1:0] r_chk_idx;
    logic        r_found;
    logic [AW-1:0] r_hit_idx;
    logic [47:0] r_hit_mac;
    logic        r_free_found;
    logic [AW-1:0] r_free_idx;
    logic        r_out_valid;
    t_out        r_out, n_out;

    logic        cfg_write;
    logic        in_accept;
    logic        slot_free;
    logic        scan_done;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic        rd_valid;
    logic [31:0] rd_ip;
    logic [47:0] rd_mac;
    logic [7:0]  rd_port;
    logic [31:0] key_ip;
    logic        use_port;
    logic        is_learn;
    logic        hit_now;
    logic        free_now;
    logic        needs_scan;
    t_tbl_ctl    tbl_ctl, fin_ctl;
    logic [AW-1:0] wr_addr;

    // ---------------- Configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dynamic_arp <= 1'b0;
            r_local_mac   <= '0;
            r_local_ip    <= '0;
        end else if (cfg_write) begin
            unique case (paddr[4:3])
                REG_DYNAMIC_ARP: r_dynamic_arp <= pwdata[0];
                REG_LOCAL_MAC:   r_local_mac   <= pwdata[47:0];
                REG_LOCAL_IP:    r_local_ip    <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_DYNAMIC_ARP: prdata = {63'd0, r_dynamic_arp};
            REG_LOCAL_MAC:   prdata = {16'd0, r_local_mac};
            REG_LOCAL_IP:    prdata = {32'd0, r_local_ip};
            default:         prdata = '0;
        endcase
    end

    // ---------------- Table ----------------
    arpc_table #(
        .ENTRIES (TABLE_ENTRIES),
        .AW      (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (tbl_ctl),
        .i_wr_addr  (wr_addr),
        .i_wr_ip    (r_item.peer_ip),
        .i_wr_mac   (r_item.peer_mac),
        .i_wr_port  (r_item.port),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .o_rd_valid (rd_valid),
        .o_rd_ip    (rd_ip),
        .o_rd_mac   (rd_mac),
        .o_rd_port  (rd_port)
    );

    // ---------------- Shared compare unit ----------------
    assign is_learn = (r_item.kind == KIND_ADD) ||
                      (r_item.kind == KIND_PKT && r_item.arp_operation == OP_REPLY);
    assign use_port = (r_item.kind == KIND_DEL) || (r_item.kind == KIND_RESOLVE);
    assign key_ip   = (r_item.kind == KIND_RESOLVE) ? r_item.target_ip : r_item.peer_ip;
    assign hit_now  = r_chk && rd_valid && (rd_ip == key_ip) &&
                      (!use_port || rd_port == r_item.port);
    assign free_now = r_chk && !rd_valid;

    // A received packet other than a reply never touches the table.
    assign needs_scan = !(i_in_data.kind == KIND_PKT && i_in_data.arp_operation != OP_REPLY);
    assign scan_done  = (r_cnt == CW'(TABLE_ENTRIES));
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // ---------------- Next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = needs_scan ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- Sequencer outputs ----------------
    always_comb begin
        o_in_stall = 1'b1;
        rd_en      = 1'b0;
        rd_addr    = r_cnt[AW-1:0];
        tbl_ctl    = '0;
        unique case (r_state)
            ST_IDLE:   o_in_stall = 1'b0;
            ST_SCAN:   rd_en = !scan_done;
            ST_FINISH: begin
                if (slot_free) begin
                    tbl_ctl = fin_ctl;
                end
            end
            default: ;
        endcase
    end

    // ---------------- Result and table update ----------------
    always_comb begin
        n_out   = '0;
        fin_ctl = '0;
        wr_addr = r_found ? r_hit_idx : r_free_idx;
        unique case (r_item.kind)
            KIND_PKT, KIND_ADD: begin
                if (is_learn) begin
                    priority if (r_found) begin
                        fin_ctl.mac_we = 1'b1;
                        n_out.status   = STAT_DONE;
                    end else if (r_free_found) begin
                        fin_ctl.key_we    = 1'b1;
                        fin_ctl.mac_we    = 1'b1;
                        fin_ctl.set_valid = 1'b1;
                        n_out.status      = STAT_DONE;
                    end else begin
                        n_out.status = STAT_FULL;
                    end
                end else if (r_item.arp_operation == OP_REQUEST &&
                             r_item.target_ip == r_local_ip) begin
                    n_out.status         = STAT_REPLY;
                    n_out.out_port       = r_item.port;
                    n_out.out_operation  = OUT_OP_REPLY;
                    n_out.out_sender_mac = r_local_mac;
                    n_out.out_sender_ip  = r_item.target_ip;
                    n_out.out_target_mac = r_item.peer_mac;
                    n_out.out_target_ip  = r_item.peer_ip;
                end else begin
                    n_out.status = STAT_DONE;
                end
            end
            KIND_DEL: begin
                if (r_found) begin
                    fin_ctl.clr_valid = 1'b1;
                    n_out.status      = STAT_DONE;
                end else begin
                    n_out.status = STAT_DEL_MISSING;
                end
            end
            KIND_RESOLVE: begin
                priority if (r_found) begin
                    n_out.status       = STAT_HIT;
                    n_out.resolved_mac = r_hit_mac;
                end else if (r_item.cache_only) begin
                    n_out.status = STAT_MISS;
                end else if (r_dynamic_arp) begin
                    n_out.status         = STAT_REQUEST;
                    n_out.out_port       = r_item.port;
                    n_out.out_operation  = OUT_OP_REQUEST;
                    n_out.out_sender_mac = r_local_mac;
                    n_out.out_sender_ip  = r_local_ip;
                    n_out.out_target_ip  = r_item.target_ip;
                end else begin
                    n_out.status = STAT_NO_RECORD;
                end
            end
            default: n_out = '0;
        endcase
    end

    // ---------------- Registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_chk        <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                r_cnt        <= '0;
                r_chk        <= 1'b0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                if (!scan_done) begin
                    r_cnt <= r_cnt + CW'(1);
                end
                r_chk <= !scan_done;
                // Only the first match and the lowest free entry count.
                if (hit_now && !r_found) begin
                    r_found <= 1'b1;
                end
                if (free_now && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end
            if (r_state == ST_FINISH && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in_data;
        end
        if (r_state == ST_SCAN) begin
            r_chk_idx <= r_cnt[AW-1:0];
            if (hit_now && !r_found) begin
                r_hit_idx <= r_chk_idx;
                r_hit_mac <= rd_mac;
            end
            if (free_now && !r_free_found) begin
                r_free_idx <= r_chk_idx;
            end
        end
        if (r_state == ST_FINISH && slot_free) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------- Assertions ----------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TABLE_ENTRIES))
        else $error("scan counter ran past the table");

    a_write_in_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tbl_ctl.key_we || tbl_ctl.mac_we || tbl_ctl.set_valid || tbl_ctl.clr_valid)
        |-> r_state == ST_FINISH)
        else $error("table written outside the finish step");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_FINISH)
        else $error("result appeared without a finished transaction");

    a_chk_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk |-> r_state == ST_SCAN)
        else $error("table compare pending outside the scan");

endmodule

/* tb/arp_cache_and_responder_unit_tb.sv */
// Self-checking testbench for arp_cache_and_responder_unit.
// Depends on arpc_pkg and the top level; a scoreboard class tracks the ARP table and
// predicts every result, plain tasks drive the item stream and the APB port.
module arp_cache_and_responder_unit_tb;
    import arpc_pkg::*;

    localparam int ENTRIES            = TABLE_ENTRIES_DEF;
    localparam int DRAIN_CYCLES       = 30;
    localparam int LONG_HOLD          = 400;
    localparam int WATCHDOG_LIMIT     = 2000;
    localparam int RANDOM_PER_SETTING = 100;
    localparam int POOL_IPS           = 20;

    class arp_cache_tracker;
        bit          dyn_arp;
        logic [47:0] own_mac;
        logic [31:0] own_ip;
        bit          ent_valid[ENTRIES];
        logic [31:0] ent_ip[ENTRIES];
        logic [47:0] ent_mac[ENTRIES];
        logic [7:0]  ent_port[ENTRIES];
        t_out        expected_results[$];
        int          checked;
        int          mismatches;
        int          status_seen[8];

        function new();
            dyn_arp = 0;
            own_mac = '0;
            own_ip  = '0;
            for (int i = 0; i < ENTRIES; i++) begin
                ent_valid[i] = 0;
                ent_ip[i]    = '0;
                ent_mac[i]   = '0;
                ent_port[i]  = '0;
            end
            for (int s = 0; s < 8; s++) status_seen[s] = 0;
            checked    = 0;
            mismatches = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [63:0] value);
            case (idx)
                REG_DYNAMIC_ARP: dyn_arp = value[0];
                REG_LOCAL_MAC:   own_mac = value[47:0];
                REG_LOCAL_IP:    own_ip  = value[31:0];
                default: ;
            endcase
        endfunction

        // A known IP only gets its MAC refreshed; the port of the entry is kept.
        function logic [2:0] learn_binding(logic [31:0] ip, logic [47:0] mac, logic [7:0] port);
            for (int i = 0; i < ENTRIES; i++) begin
                if (ent_valid[i] && ent_ip[i] == ip) begin
                    ent_mac[i] = mac;
                    return STAT_DONE;
                end
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (!ent_valid[i]) begin
                    ent_valid[i] = 1;
                    ent_ip[i]    = ip;
                    ent_mac[i]   = mac;
                    ent_port[i]  = port;
                    return STAT_DONE;
                end
            end
            return STAT_FULL;
        endfunction

        function t_out predict_result(t_in it);
            t_out r;
            bit   hit;
            r   = '0;
            hit = 0;
            r.status = STAT_DONE;
            case (it.kind)
                KIND_PKT: begin
                    if (it.arp_operation == OP_REPLY) begin
                        r.status = learn_binding(it.peer_ip, it.peer_mac, it.port);
                    end else if (it.arp_operation == OP_REQUEST && it.target_ip == own_ip) begin
                        r.status         = STAT_REPLY;
                        r.out_port       = it.port;
                        r.out_operation  = OUT_OP_REPLY;
                        r.out_sender_mac = own_mac;
                        r.out_sender_ip  = it.target_ip;
                        r.out_target_mac = it.peer_mac;
                        r.out_target_ip  = it.peer_ip;
                    end
                end
                KIND_ADD: begin
                    r.status = learn_binding(it.peer_ip, it.peer_mac, it.port);
                end
                KIND_DEL: begin
                    r.status = STAT_DEL_MISSING;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (ent_valid[i] && ent_ip[i] == it.peer_ip &&
                            ent_port[i] == it.port) begin
                            ent_valid[i] = 0;
                            r.status = STAT_DONE;
                            break;
                        end
                    end
                end
                default: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (ent_valid[i] && ent_ip[i] == it.target_ip &&
                            ent_port[i] == it.port) begin
                            r.resolved_mac = ent_mac[i];
                            hit = 1;
                            break;
                        end
                    end
                    if (hit) begin
                        r.status = STAT_HIT;
                    end else if (it.cache_only) begin
                        r.status = STAT_MISS;
                    end else if (dyn_arp) begin
                        r.status         = STAT_REQUEST;
                        r.out_port       = it.port;
                        r.out_operation  = OUT_OP_REQUEST;
                        r.out_sender_mac = own_mac;
                        r.out_sender_ip  = own_ip;
                        r.out_target_ip  = it.target_ip;
                    end else begin
                        r.status = STAT_NO_RECORD;
                    end
                end
            endcase
            return r;
        endfunction

        function void note_item(t_in it);
            expected_results.insert(expected_results.size(), predict_result(it));
        endfunction

        function string describe(t_out r);
            return $sformatf("st=%0d port=%0d op=%0d smac=%h sip=%h tmac=%h tip=%h rmac=%h",
                             r.status, r.out_port, r.out_operation, r.out_sender_mac,
                             r.out_sender_ip, r.out_target_mac, r.out_target_ip, r.resolved_mac);
        endfunction

        function void report_mismatch(string what, t_out want, t_out got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("MISMATCH %0d at %0t: %s", mismatches, $realtime, what);
                $display("  expected %s", describe(want));
                $display("  actual   %s", describe(got));
            end
        endfunction

        function void check_result(t_out got);
            t_out  want;
            string bad;
            if (expected_results.size() == 0) begin
                report_mismatch("result with no transaction outstanding", '0, got);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            status_seen[want.status]++;
            bad = "";
            if (got.status !== want.status) bad = {bad, " status"};
            if (got.out_port !== want.out_port) bad = {bad, " out_port"};
            if (got.out_operation !== want.out_operation) bad = {bad, " out_operation"};
            if (got.out_sender_mac !== want.out_sender_mac) bad = {bad, " out_sender_mac"};
            if (got.out_sender_ip !== want.out_sender_ip) bad = {bad, " out_sender_ip"};
            if (got.out_target_mac !== want.out_target_mac) bad = {bad, " out_target_mac"};
            if (got.out_target_ip !== want.out_target_ip) bad = {bad, " out_target_ip"};
            if (got.resolved_mac !== want.resolved_mac) bad = {bad, " resolved_mac"};
            if (bad != "") report_mismatch({"wrong field(s):", bad}, want, got);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out                  o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    arp_cache_tracker trk;
    bit               tx_idle_on;
    bit               rx_idle_on;
    int               hold_requests;
    int               hold_seen;
    int               hold_left;
    int               rx_wait;
    int               quiet_cycles;
    int               items_sent;
    int               settings_used;
    logic [31:0]      ip_pool[POOL_IPS];
    logic [7:0]       port_pool[3];

    arp_cache_and_responder_unit u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side: check each accepted transaction, then draw how long to hold off the next.
    always @(posedge i_clk) begin
        bit accepted;
        accepted = 0;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait   = 0;
            hold_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                trk.check_result(o_out_data);
                accepted = 1;
                rx_wait  = rx_idle_on ? $urandom_range(0, 18) : 0;
            end
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                if (o_out_valid && !accepted) rx_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         quiet_cycles, trk.expected_results.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic logic [47:0] rand_mac();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[47:0];
    endfunction

    function automatic logic [31:0] pick_ip();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return ip_pool[$urandom_range(0, POOL_IPS - 1)];
    endfunction

    function automatic logic [7:0] pick_port();
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
        return port_pool[$urandom_range(0, 2)];
    endfunction

    function automatic t_in arp_item(logic [1:0] kind, logic [7:0] port, logic [15:0] op,
                                     logic [47:0] mac, logic [31:0] pip, logic [31:0] tip,
                                     logic conly);
        t_in it;
        it.kind          = kind;
        it.port          = port;
        it.arp_operation = op;
        it.peer_mac      = mac;
        it.peer_ip       = pip;
        it.target_ip     = tip;
        it.cache_only    = conly;
        return it;
    endfunction

    // Mostly well-formed table traffic over a small address pool so the table fills,
    // with fields the kind does not use left random.
    function automatic t_in random_item();
        t_in it;
        int  pick;
        it = arp_item(KIND_PKT, pick_port(), 16'($urandom), rand_mac(), pick_ip(), pick_ip(),
                      $urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            it.arp_operation = OP_REPLY;
        end else if (pick < 22) begin
            it.arp_operation = OP_REQUEST;
            if ($urandom_range(0, 3) != 0) it.target_ip = trk.own_ip;
        end else if (pick < 28) begin
            it.kind = KIND_PKT;
        end else if (pick < 55) begin
            it.kind = KIND_ADD;
        end else if (pick < 68) begin
            it.kind = KIND_DEL;
        end else begin
            it.kind = KIND_RESOLVE;
        end
        return it;
    endfunction

    task automatic send_item(input t_in it);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        trk.note_item(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (trk.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        trk.set_register(idx, value);
    endtask

    task automatic configure(input bit dyn, input logic [47:0] mac, input logic [31:0] ip);
        wait_drained();
        write_reg(REG_DYNAMIC_ARP, {63'd0, dyn});
        write_reg(REG_LOCAL_MAC, {16'd0, mac});
        write_reg(REG_LOCAL_IP, {32'd0, ip});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_used++;
    endtask

    initial begin
        logic [31:0] ip_a;
        logic [47:0] ones48;
        trk           = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_out_stall   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tx_idle_on    = 1;
        rx_idle_on    = 1;
        hold_requests = 0;
        hold_seen     = 0;
        quiet_cycles  = 0;
        items_sent    = 0;
        settings_used = 1;
        ip_a          = 32'hC0A8_0001;
        ones48        = 48'hFFFF_FFFF_FFFF;
        ip_pool[0]    = 32'h0000_0000;
        ip_pool[1]    = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_IPS; i++) ip_pool[i] = $urandom;
        port_pool[0]  = 8'd0;
        port_pool[1]  = 8'd255;
        port_pool[2]  = 8'($urandom_range(1, 254));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: no dynamic ARP, local address all zero.
        send_item(arp_item(KIND_RESOLVE, 8'd0, 16'd0, 48'd0, 32'd0, 32'd0, 1'b0));
        send_item(arp_item(KIND_RESOLVE, 8'd255, 16'hFFFF, ones48, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 1'b1));
        send_item(arp_item(KIND_PKT, 8'd255, OP_REQUEST, ones48, 32'hFFFF_FFFF, 32'd0, 1'b1));

        configure(1'b1, ones48, 32'hFFFF_FFFF);
        send_item(arp_item(KIND_RESOLVE, 8'd255, 16'd0, 48'd0, 32'd0, 32'h0A00_0001, 1'b0));
        send_item(arp_item(KIND_PKT, 8'd0, OP_REQUEST, 48'd0, 32'd0, 32'hFFFF_FFFF, 1'b0));
        // Requests for someone else and unknown opcodes are dropped.
        send_item(arp_item(KIND_PKT, 8'd3, OP_REQUEST, rand_mac(), ip_a, 32'h0A00_0001, 1'b0));
        send_item(arp_item(KIND_PKT, 8'd3, 16'h0000, rand_mac(), ip_a, 32'hFFFF_FFFF, 1'b0));
        send_item(arp_item(KIND_PKT, 8'd3, 16'hFFFF, rand_mac(), ip_a, 32'hFFFF_FFFF, 1'b0));
        send_item(arp_item(KIND_PKT, 8'd3, 16'h0003, rand_mac(), ip_a, 32'hFFFF_FFFF, 1'b0));
        // Learn from a reply, then refresh the MAC through an add on another port.
        send_item(arp_item(KIND_PKT, 8'd5, OP_REPLY, 48'h0200_0000_0001, ip_a, 32'd0, 1'b0));
        send_item(arp_item(KIND_RESOLVE, 8'd5, 16'd0, 48'd0, 32'd0, ip_a, 1'b0));
        send_item(arp_item(KIND_RESOLVE, 8'd6, 16'd0, 48'd0, 32'd0, ip_a, 1'b0));
        send_item(arp_item(KIND_ADD, 8'd9, 16'd0, ones48, ip_a, 32'd0, 1'b0));
        send_item(arp_item(KIND_RESOLVE, 8'd5, 16'd0, 48'd0, 32'd0, ip_a, 1'b1));
        // Delete has to match the port that the entry kept.
        send_item(arp_item(KIND_DEL, 8'd9, 16'd0, 48'd0, ip_a, 32'd0, 1'b0));
        send_item(arp_item(KIND_DEL, 8'd5, 16'd0, 48'd0, ip_a, 32'd0, 1'b0));
        send_item(arp_item(KIND_DEL, 8'd5, 16'd0, 48'd0, ip_a, 32'd0, 1'b0));
        send_item(arp_item(KIND_ADD, 8'd0, 16'd0, 48'd0, 32'd0, 32'd0, 1'b0));
        send_item(arp_item(KIND_RESOLVE, 8'd0, 16'd0, 48'd0, 32'd0, 32'd0, 1'b0));
        send_item(arp_item(KIND_ADD, 8'd255, 16'hFFFF, ones48, 32'hFFFF_FFFF, 32'd0, 1'b1));
        send_item(arp_item(KIND_RESOLVE, 8'd255, 16'd0, 48'd0, 32'd0, 32'hFFFF_FFFF, 1'b1));

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: configure(1'b1, rand_mac(), ip_pool[3]);
                1: configure(1'b0, 48'd0, 32'd0);
                2: configure(1'b1, ones48, 32'hFFFF_FFFF);
                default: configure(1'b0, rand_mac(), ip_pool[5]);
            endcase
            for (int n = 0; n < RANDOM_PER_SETTING; n++) begin
                if (n % 25 == 0) begin
                    tx_idle_on = $urandom_range(0, 2) != 0;
                    rx_idle_on = $urandom_range(0, 2) != 0;
                    // Back-to-back items against a long result hold-off fill the pipeline.
                    if (ph == 1 && n == 0) begin
                        tx_idle_on = 0;
                        hold_requests++;
                    end
                end
                if (ph == 2 && n == 50) wait_drained();
                send_item(random_item());
            end
        end
        wait_drained();

        $display("run covered %0d items under %0d register settings, %0d results checked",
                 items_sent, settings_used, trk.checked);
        $display({"statuses done/reply/request/hit/miss/del-missing/no-record/full: ",
                  "%0d %0d %0d %0d %0d %0d %0d %0d"},
                 trk.status_seen[0], trk.status_seen[1], trk.status_seen[2], trk.status_seen[3],
                 trk.status_seen[4], trk.status_seen[5], trk.status_seen[6], trk.status_seen[7]);
        if (trk.mismatches == 0 && trk.expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
